@@ rtl/rrbs_pkg.sv @@
// Shared constants and types for the round-robin backend selector.
package rrbs_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int TIME_W          = 32;
    localparam int COUNT_REG_W     = 5;
    localparam int DELAY_W         = 16;
    localparam int SIDX_W          = 4;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [COUNT_REG_W-1:0] SERVER_COUNT_RST = '0;
    localparam logic [DELAY_W-1:0]     RETRY_DELAY_RST  = 16'd30;

    typedef enum logic {
        ACT_SELECT = 1'b0,
        ACT_FAIL   = 1'b1
    } t_action;

    typedef enum logic {
        REG_SERVER_COUNT = 1'b0,
        REG_RETRY_DELAY  = 1'b1
    } t_reg_idx;

    typedef enum logic {
        ALU_CMP = 1'b0,
        ALU_ADD = 1'b1
    } t_alu_op;

endpackage

@@ rtl/rrbs_time_alu.sv @@
// Shared 32-bit time unit: retry-time sum or now-versus-retry compare.
module rrbs_time_alu (
    input  rrbs_pkg::t_alu_op              i_op,
    input  logic [rrbs_pkg::TIME_W-1:0]    i_a,
    input  logic [rrbs_pkg::TIME_W-1:0]    i_b,
    output logic [rrbs_pkg::TIME_W-1:0]    o_sum,
    output logic                           o_ge
);

    logic [rrbs_pkg::TIME_W-1:0] b_op;
    logic [rrbs_pkg::TIME_W:0]   full;

    // compare runs as a - b; carry out set means a >= b
    always_comb begin
        b_op = (i_op == rrbs_pkg::ALU_CMP) ? ~i_b : i_b;
        full = {1'b0, i_a} + {1'b0, b_op}
             + {{rrbs_pkg::TIME_W{1'b0}}, (i_op == rrbs_pkg::ALU_CMP)};
        o_sum = full[rrbs_pkg::TIME_W-1:0];
        o_ge  = full[rrbs_pkg::TIME_W];
    end

endmodule

@@ rtl/rrbs_retry_mem.sv @@
// Retry-time memory: one write port, one registered read port.
module rrbs_retry_mem #(
    parameter int DEPTH = rrbs_pkg::MAX_SERVERS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [rrbs_pkg::TIME_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [rrbs_pkg::TIME_W-1:0] o_rdata
);

    logic [rrbs_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [rrbs_pkg::TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/round_robin_backend_select.sv @@
// Top level: round-robin backend selector with failure holdoff.
//
// Command channel: an item is taken at a clock edge with start high and busy
// low. A select item (action 0) scans servers from the cursor, skipping
// servers marked down unless now_time has reached their retry time, and
// returns one result. A failure item (action 1) marks server_index down
// with retry time now_time + retry_delay and returns nothing.
// Results appear for exactly one cycle on o_found / o_chosen_index, marked
// by o_result_valid; the receiver cannot stall, so nothing is held back.
// Timing: a select visits one slot per cycle through the retry-time memory
// read port and the shared time unit, visiting 1 to server_count+1 slots
// (count clamped to capacity, at most 17 for 16 servers), and the result
// strobe comes in the cycle after the last visit. With a zero server count
// the result comes the cycle after acceptance and busy stays low. A failure
// item holds busy for one cycle while its retry time is written. The user
// writes configuration (APB, server_count at 0x0, retry_delay at 0x4) only
// while idle; the block does not enforce this. Reset clears all down flags,
// the cursor and the registers to their defaults; no clearing pass is needed.
module round_robin_backend_select #(
    parameter int MAX_SERVERS = rrbs_pkg::MAX_SERVERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_action,
    input  logic [rrbs_pkg::SIDX_W-1:0]         i_server_index,
    input  logic [rrbs_pkg::TIME_W-1:0]         i_now_time,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic [rrbs_pkg::SIDX_W-1:0]         o_chosen_index,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rrbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rrbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rrbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FAIL
    } t_state;

    t_state                              r_state, n_state;
    logic [IDX_W-1:0]                    r_pos, n_pos;
    logic [CNT_W-1:0]                    r_tries, n_tries;
    logic [IDX_W-1:0]                    r_cursor, n_cursor;
    logic [MAX_SERVERS-1:0]              r_down, n_down;
    logic [rrbs_pkg::TIME_W-1:0]         r_now, n_now;
    logic [IDX_W-1:0]                    r_fail_idx, n_fail_idx;
    logic                                r_fail_en, n_fail_en;
    logic                                r_res_valid, n_res_valid;
    logic                                r_found, n_found;
    logic [rrbs_pkg::SIDX_W-1:0]         r_chosen, n_chosen;
    logic [rrbs_pkg::COUNT_REG_W-1:0]    r_count;
    logic [rrbs_pkg::DELAY_W-1:0]        r_delay;

    logic [31:0]                         count_ext;
    logic [CNT_W-1:0]                    srv_num;
    logic [IDX_W-1:0]                    start_pos;
    logic [CNT_W-1:0]                    pos_inc;
    logic [IDX_W-1:0]                    next_pos;
    logic                                live;
    logic                                accept;
    logic                                cfg_wr;

    logic [IDX_W-1:0]                    rd_addr;
    logic [rrbs_pkg::TIME_W-1:0]         rd_data;
    rrbs_pkg::t_alu_op                   alu_op;
    logic [rrbs_pkg::TIME_W-1:0]         alu_b;
    logic [rrbs_pkg::TIME_W-1:0]         alu_sum;
    logic                                alu_ge;

    rrbs_retry_mem #(
        .DEPTH (MAX_SERVERS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_FAIL) && r_fail_en),
        .i_waddr (r_fail_idx),
        .i_wdata (alu_sum),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rrbs_time_alu u_alu (
        .i_op  (alu_op),
        .i_a   (r_now),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_ge  (alu_ge)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    assign o_result_valid = r_res_valid;
    assign o_found        = r_found;
    assign o_chosen_index = r_chosen;

    always_comb begin
        unique case (rrbs_pkg::t_reg_idx'(paddr[2]))
            rrbs_pkg::REG_SERVER_COUNT:
                prdata = {{(rrbs_pkg::APB_DATA_W-rrbs_pkg::COUNT_REG_W){1'b0}}, r_count};
            rrbs_pkg::REG_RETRY_DELAY:
                prdata = {{(rrbs_pkg::APB_DATA_W-rrbs_pkg::DELAY_W){1'b0}}, r_delay};
            default: prdata = '0;
        endcase
    end

    // clamp the configured count to capacity and derive scan positions
    always_comb begin
        count_ext = 32'(r_count);
        srv_num   = (count_ext > 32'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS)
                                                   : CNT_W'(count_ext);
        start_pos = (CNT_W'(r_cursor) < srv_num) ? r_cursor : '0;
        pos_inc   = CNT_W'(r_pos) + CNT_W'(1);
        next_pos  = (pos_inc >= srv_num) ? '0 : IDX_W'(pos_inc);
        live      = !r_down[r_pos] || alu_ge;
        alu_op    = (r_state == S_FAIL) ? rrbs_pkg::ALU_ADD : rrbs_pkg::ALU_CMP;
        alu_b     = (r_state == S_FAIL) ? rrbs_pkg::TIME_W'(r_delay) : rd_data;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_tries     = r_tries;
        n_cursor    = r_cursor;
        n_down      = r_down;
        n_now       = r_now;
        n_fail_idx  = r_fail_idx;
        n_fail_en   = r_fail_en;
        n_res_valid = 1'b0;
        n_found     = r_found;
        n_chosen    = r_chosen;
        rd_addr     = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now = i_now_time;
                    priority if (rrbs_pkg::t_action'(i_action) == rrbs_pkg::ACT_FAIL) begin
                        n_fail_en  = (32'(i_server_index) < 32'(MAX_SERVERS));
                        n_fail_idx = IDX_W'(32'(i_server_index));
                        n_state    = S_FAIL;
                    end else if (srv_num == '0) begin
                        // no servers: answer not found at once
                        n_cursor    = '0;
                        n_res_valid = 1'b1;
                        n_found     = 1'b0;
                        n_chosen    = '0;
                    end else begin
                        n_pos   = start_pos;
                        n_tries = '0;
                        rd_addr = start_pos;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (live || (r_tries == srv_num)) begin
                    n_cursor    = next_pos;
                    n_res_valid = 1'b1;
                    n_found     = live;
                    n_chosen    = live ? rrbs_pkg::SIDX_W'(32'(r_pos)) : '0;
                    if (live) begin
                        n_down[r_pos] = 1'b0;
                    end
                    n_state = S_IDLE;
                end else begin
                    // advance and fetch the next slot's retry time
                    n_pos   = next_pos;
                    n_tries = r_tries + CNT_W'(1);
                    rd_addr = next_pos;
                end
            end
            S_FAIL: begin
                if (r_fail_en) begin
                    n_down[r_fail_idx] = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_tries    <= n_tries;
        r_now      <= n_now;
        r_fail_idx <= n_fail_idx;
        r_found    <= n_found;
        r_chosen   <= n_chosen;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_down      <= '0;
            r_res_valid <= 1'b0;
            r_fail_en   <= 1'b0;
            r_count     <= rrbs_pkg::SERVER_COUNT_RST;
            r_delay     <= rrbs_pkg::RETRY_DELAY_RST;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_down      <= n_down;
            r_res_valid <= n_res_valid;
            r_fail_en   <= n_fail_en;
            if (cfg_wr) begin
                unique case (rrbs_pkg::t_reg_idx'(paddr[2]))
                    rrbs_pkg::REG_SERVER_COUNT:
                        r_count <= pwdata[rrbs_pkg::COUNT_REG_W-1:0];
                    rrbs_pkg::REG_RETRY_DELAY:
                        r_delay <= pwdata[rrbs_pkg::DELAY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/sv/tb_round_robin_backend_select.sv @@
// Self-checking testbench for the round-robin backend selector: random and directed commands.
module tb_round_robin_backend_select;
    timeunit 1ns;
    timeprecision 1ps;

    import rrbs_pkg::*;

    localparam int N_SLOTS      = MAX_SERVERS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;

    typedef struct {
        t_action           action;
        logic [SIDX_W-1:0] sidx;
        logic [TIME_W-1:0] now_s;
    } t_cmd;

    typedef struct {
        logic              found;
        logic [SIDX_W-1:0] idx;
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_action = 1'b0;
    logic [SIDX_W-1:0]     i_server_index = '0;
    logic [TIME_W-1:0]     i_now_time = '0;
    logic                  o_result_valid;
    logic                  o_found;
    logic [SIDX_W-1:0]     o_chosen_index;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the selector's configuration and server table
    logic [COUNT_REG_W-1:0] cfg_count = SERVER_COUNT_RST;
    logic [DELAY_W-1:0]     cfg_delay = RETRY_DELAY_RST;
    logic                   srv_down [N_SLOTS];
    logic [TIME_W-1:0]      srv_retry [N_SLOTS];
    int                     rr_cursor = 0;

    t_cmd  pending_cmds[$];
    t_cmd  cmd_now;
    t_pick expected_picks[$];
    int    send_idle_pct = 24;
    logic [TIME_W-1:0] sim_now = '0;

    int err_cnt = 0;
    int n_selects = 0;
    int n_fails = 0;
    int n_found = 0;
    int n_missed = 0;
    int n_cfg_writes = 0;
    int stall_cnt = 0;

    round_robin_backend_select u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_server_index (i_server_index),
        .i_now_time     (i_now_time),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_chosen_index (o_chosen_index),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < N_SLOTS; i++) begin
            srv_down[i]  = 1'b0;
            srv_retry[i] = '0;
        end
    end

    // Advance the server table by one command; a select yields the expected pick.
    function automatic void apply_cmd(input t_cmd c);
        int    n;
        int    pos;
        int    tries;
        t_pick pick;
        if (c.action == ACT_FAIL) begin
            srv_down[c.sidx]  = 1'b1;
            srv_retry[c.sidx] = c.now_s + TIME_W'(cfg_delay);
            n_fails++;
            return;
        end
        n_selects++;
        n = (int'(cfg_count) > N_SLOTS) ? N_SLOTS : int'(cfg_count);
        pick.found = 1'b0;
        pick.idx   = '0;
        if (n == 0) begin
            rr_cursor = 0;
            expected_picks.push_back(pick);
            return;
        end
        pos   = (rr_cursor < n) ? rr_cursor : 0;
        tries = 0;
        while (!pick.found && tries <= n) begin
            if (srv_down[pos] && c.now_s >= srv_retry[pos])
                srv_down[pos] = 1'b0;
            if (!srv_down[pos]) begin
                pick.found = 1'b1;
                pick.idx   = SIDX_W'(pos);
            end
            pos = (pos + 1 >= n) ? 0 : pos + 1;
            tries++;
        end
        rr_cursor = pos;
        expected_picks.push_back(pick);
    endfunction

    // driver: present queued commands, holding each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                apply_cmd(cmd_now);
            if (!start || !busy) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_now = pending_cmds.pop_front();
                    start          <= 1'b1;
                    i_action       <= cmd_now.action;
                    i_server_index <= cmd_now.sidx;
                    i_now_time     <= cmd_now.now_s;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result strobe with the oldest expected pick
    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && o_result_valid) begin
            if (expected_picks.size() == 0) begin
                $error("result with no selection outstanding: found=%0b chosen_index=%0d",
                       o_found, o_chosen_index);
                err_cnt++;
            end else begin
                exp_pick = expected_picks.pop_front();
                if (o_found !== exp_pick.found) begin
                    $error("found mismatch: expected %0b, got %0b", exp_pick.found, o_found);
                    err_cnt++;
                end
                if (o_chosen_index !== exp_pick.idx) begin
                    $error("chosen_index mismatch: expected %0d, got %0d",
                           exp_pick.idx, o_chosen_index);
                    err_cnt++;
                end
                if (exp_pick.found)
                    n_found++;
                else
                    n_missed++;
            end
        end
    end

    // watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable && pwrite && pready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || busy || expected_picks.size() != 0)
            @(negedge i_clk);
        // a failure command leaves no result behind, so give the block time to settle
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx r, input logic [APB_DATA_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_SERVER_COUNT)
            cfg_count = v[COUNT_REG_W-1:0];
        else
            cfg_delay = v[DELAY_W-1:0];
        n_cfg_writes++;
    endtask

    task automatic configure(input int count, input int delay);
        wait_drained();
        reg_write(REG_SERVER_COUNT, APB_DATA_W'(count));
        reg_write(REG_RETRY_DELAY, APB_DATA_W'(delay));
    endtask

    task automatic push_cmd(input t_action a, input int sidx, input logic [TIME_W-1:0] t);
        t_cmd c;
        c.action = a;
        c.sidx   = SIDX_W'(sidx);
        c.now_s  = t;
        pending_cmds.push_back(c);
    endtask

    // Mostly a slowly advancing clock with failures aimed at servers in use,
    // plus time jumps, wrap-around and stray timestamps.
    task automatic queue_random(input int n_cmds);
        int    live_n;
        int    step_max;
        int    roll;
        t_cmd  c;
        live_n   = (int'(cfg_count) > N_SLOTS) ? N_SLOTS : int'(cfg_count);
        step_max = int'(cfg_delay) / 4 + 2;
        for (int k = 0; k < n_cmds; k++) begin
            roll = $urandom_range(99);
            if (roll < 3)
                sim_now = $urandom();
            else if (roll < 5)
                sim_now = 32'hFFFF_FFFF - TIME_W'($urandom_range(step_max * 4));
            else
                sim_now = sim_now + TIME_W'($urandom_range(step_max));
            c.action = ($urandom_range(99) < 35) ? ACT_FAIL : ACT_SELECT;
            if (live_n > 0 && $urandom_range(3) != 0)
                c.sidx = SIDX_W'($urandom_range(live_n - 1));
            else
                c.sidx = SIDX_W'($urandom_range(N_SLOTS - 1));
            c.now_s = ($urandom_range(99) < 3) ? TIME_W'($urandom()) : sim_now;
            pending_cmds.push_back(c);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no servers configured, fail an unused server with wrapping retry time
        send_idle_pct = 24;
        push_cmd(ACT_SELECT, 0, 32'd0);
        push_cmd(ACT_FAIL, 15, 32'hFFFF_FFFF);
        push_cmd(ACT_SELECT, 9, 32'd100);

        // take every server of three down, then revive one at its retry time
        configure(3, 0);
        push_cmd(ACT_SELECT, 0, 32'd1);
        push_cmd(ACT_SELECT, 0, 32'd1);
        push_cmd(ACT_FAIL, 0, 32'd10);
        push_cmd(ACT_FAIL, 1, 32'd10);
        push_cmd(ACT_FAIL, 2, 32'd10);
        push_cmd(ACT_SELECT, 5, 32'd9);
        push_cmd(ACT_SELECT, 0, 32'd10);

        // count above capacity, longest delay, retry time wrapping to zero
        configure(31, 65535);
        push_cmd(ACT_SELECT, 0, 32'd0);
        push_cmd(ACT_FAIL, 4, 32'hFFFF_0001);
        push_cmd(ACT_FAIL, 15, 32'hFFFF_0000);
        push_cmd(ACT_SELECT, 15, 32'd0);
        push_cmd(ACT_SELECT, 0, 32'hFFFF_FFFF);

        // shrink the count so the stored cursor lands out of range
        configure(2, 30);
        push_cmd(ACT_SELECT, 0, 32'hFFFF_FFFF);
        push_cmd(ACT_SELECT, 0, 32'd0);
        push_cmd(ACT_FAIL, 1, 32'd0);
        push_cmd(ACT_SELECT, 0, 32'd29);

        configure(16, 1);
        push_cmd(ACT_SELECT, 0, 32'h8000_0000);
        push_cmd(ACT_SELECT, 10, 32'h7FFF_FFFF);
        push_cmd(ACT_SELECT, 0, 32'd0);

        configure(16, 30);
        queue_random(290);
        configure(3, 8);
        queue_random(290);

        send_idle_pct = 49;
        configure(20, 65535);
        queue_random(290);
        configure(1, 0);
        queue_random(290);

        send_idle_pct = 0;
        configure(2 + $urandom_range(13), $urandom_range(100));
        queue_random(290);
        configure(0, $urandom_range(65535));
        queue_random(40);

        wait_drained();
        $display("Covered %0d selections (%0d found, %0d none live) and %0d failure reports",
                 n_selects, n_found, n_missed, n_fails);
        $display("across %0d register writes, counts 0 to 31 and retry delays 0 to 65535",
                 n_cfg_writes);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rrbs_pkg.sv
rtl/rrbs_time_alu.sv
rtl/rrbs_retry_mem.sv
rtl/round_robin_backend_select.sv
tb/sv/tb_round_robin_backend_select.sv
